@@ rtl/lrtd_pkg.sv @@
// Shared constants and entry type for the LRU region tag directory.
package lrtd_pkg;

    // Directory geometry.
    localparam int ENTRIES     = 1024;
    localparam int CHUNK_BYTES = 16384;

    // Fixed field widths of the ports.
    localparam int HASH_W     = 32;
    localparam int OFFSET_W   = 48;
    localparam int BYTES_W    = 15;
    localparam int SLOT_OUT_W = 10;

    // Derived widths and counts.
    localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W       = $clog2(ENTRIES + 1);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
    localparam int CHUNK_W     = OFFSET_W - CHUNK_SHIFT;

    // Cells are grouped for the priority search.
    localparam int GROUP_SIZE = 32;
    localparam int GS_LOG     = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_LOG    = $clog2(NUM_GROUPS);
    localparam int NUM_CELLS  = NUM_GROUPS * GROUP_SIZE;

    // One directory entry as held by a cell.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [HASH_W-1:0]  hash;
        logic [CHUNK_W-1:0] chunk;
        logic [BYTES_W-1:0] bytes;
    } t_entry;

endpackage

@@ rtl/lru_region_tag_directory.sv @@
// Top level of the LRU region tag directory: cell chain, search tree and control.
// Insert: accepted while idle, then committed once the output register is free; one beat at a time.
// Lookup: compare, group reduce, group select and commit, in the order of the registered
// priority search across the cell chain.
// A finished result waits in an output register while the next beat is accepted.
// Reset clears the occupancy count, the state and the output valid; entries are not cleared.
module lru_region_tag_directory (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [lrtd_pkg::HASH_W-1:0]    i_source_hash,
    input  logic [lrtd_pkg::OFFSET_W-1:0]  i_file_offset,
    input  logic [lrtd_pkg::BYTES_W-1:0]   i_entry_bytes,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_hit,
    output logic [lrtd_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [lrtd_pkg::OFFSET_W-1:0]  o_region_start,
    output logic [lrtd_pkg::BYTES_W-1:0]   o_region_bytes,
    output logic                           o_evicted
);

    // Sequencer codes. An insert skips straight from idle to commit.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_GRP    = 3'd2;
    localparam logic [2:0] S_SEL    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Captured beat. The offset is kept as a chunk index.
    logic                           r_key_op;
    logic [lrtd_pkg::HASH_W-1:0]    r_key_hash;
    logic [lrtd_pkg::CHUNK_W-1:0]   r_key_chunk;
    logic [lrtd_pkg::BYTES_W-1:0]   r_key_bytes;

    logic [lrtd_pkg::OCC_W-1:0]     r_occ;

    // Lookup selection results.
    logic                           r_hit;
    lrtd_pkg::t_entry               r_hit_ent;
    logic [lrtd_pkg::NUM_GROUPS-1:0] r_gbefore;

    // Output register.
    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [lrtd_pkg::SLOT_W-1:0]    r_out_slot;
    logic [lrtd_pkg::CHUNK_W-1:0]   r_out_chunk;
    logic [lrtd_pkg::BYTES_W-1:0]   r_out_bytes;
    logic                           r_out_evicted;

    // Chain and tree wiring.
    lrtd_pkg::t_entry               w_entry  [lrtd_pkg::NUM_CELLS];
    logic [lrtd_pkg::NUM_CELLS-1:0] w_match;
    logic [lrtd_pkg::NUM_CELLS-1:0] w_live;
    logic [lrtd_pkg::NUM_CELLS-1:0] w_shift;
    logic [lrtd_pkg::NUM_CELLS-1:0] w_inbefore;
    logic [lrtd_pkg::NUM_GROUPS-1:0] w_gany;
    lrtd_pkg::t_entry               w_gent   [lrtd_pkg::NUM_GROUPS];
    logic [lrtd_pkg::NUM_GROUPS-1:0] w_gbefore;
    logic [lrtd_pkg::NUM_GROUPS-1:0] w_gfirst;
    lrtd_pkg::t_entry               w_sel_ent;
    lrtd_pkg::t_entry               w_head;

    logic w_in_acc;
    logic w_out_free;
    logic w_commit;
    logic w_ins_commit;
    logic w_look_commit;
    logic w_full;
    logic [lrtd_pkg::SLOT_W-1:0] w_ins_slot;

    // The input side takes one beat at a time; it waits only while an item is in flight.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // The output register can take a new result when it is empty or being drained.
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_commit      = (r_state == S_COMMIT) && w_out_free;
    assign w_ins_commit  = w_commit && r_key_op;
    assign w_look_commit = w_commit && !r_key_op;

    assign w_full = (r_occ == lrtd_pkg::OCC_W'(lrtd_pkg::ENTRIES));

    // A fresh insert takes the next free slot; a full directory reuses the slot at the tail.
    assign w_ins_slot = w_full ? w_entry[lrtd_pkg::ENTRIES-1].slot
                               : lrtd_pkg::SLOT_W'(r_occ);

    // The entry that enters the front of the chain on a commit.
    always_comb begin
        if (r_key_op) begin
            w_head.slot  = w_ins_slot;
            w_head.hash  = r_key_hash;
            w_head.chunk = r_key_chunk;
            w_head.bytes = r_key_bytes;
        end else begin
            w_head = r_hit_ent;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_operation ? S_COMMIT : S_CMP;
                end
            end
            S_CMP:    n_state = S_GRP;
            S_GRP:    n_state = S_SEL;
            S_SEL:    n_state = S_COMMIT;
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            if (w_ins_commit && !w_full) begin
                r_occ <= r_occ + lrtd_pkg::OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key_op    <= i_operation;
            r_key_hash  <= i_source_hash;
            r_key_chunk <= i_file_offset[lrtd_pkg::OFFSET_W-1:lrtd_pkg::CHUNK_SHIFT];
            r_key_bytes <= i_entry_bytes;
        end
    end

    // The cell chain. Position zero is the most recent entry. Positions at or beyond
    // the occupancy count hold stale data and never match.
    for (genvar i = 0; i < lrtd_pkg::NUM_CELLS; i++) begin : g_cell
        if (i < lrtd_pkg::ENTRIES) begin : g_live
            assign w_live[i] = (lrtd_pkg::OCC_W'(i) < r_occ);
        end else begin : g_pad
            assign w_live[i] = 1'b0;
        end

        // An insert pushes every cell back by one. A lookup hit pushes back only the
        // cells up to and including the hit, which frees the front for the hit entry.
        assign w_shift[i] = w_ins_commit ||
                            (w_look_commit && r_hit &&
                             !(r_gbefore[i / lrtd_pkg::GROUP_SIZE] || w_inbefore[i]));

        if (i == 0) begin : g_front
            lrtd_cell u_cell (
                .i_clk       (i_clk),
                .i_live      (w_live[i]),
                .i_key_hash  (r_key_hash),
                .i_key_chunk (r_key_chunk),
                .i_cmp_en    (r_state == S_CMP),
                .i_shift     (w_shift[i]),
                .i_prev      (w_head),
                .o_entry     (w_entry[i]),
                .o_match     (w_match[i])
            );
        end else begin : g_rest
            lrtd_cell u_cell (
                .i_clk       (i_clk),
                .i_live      (w_live[i]),
                .i_key_hash  (r_key_hash),
                .i_key_chunk (r_key_chunk),
                .i_cmp_en    (r_state == S_CMP),
                .i_shift     (w_shift[i]),
                .i_prev      (w_entry[i-1]),
                .o_entry     (w_entry[i]),
                .o_match     (w_match[i])
            );
        end
    end

    // First level of the search: one reducer per group of cells.
    for (genvar g = 0; g < lrtd_pkg::NUM_GROUPS; g++) begin : g_grp
        lrtd_pkg::t_entry w_loc [lrtd_pkg::GROUP_SIZE];

        for (genvar j = 0; j < lrtd_pkg::GROUP_SIZE; j++) begin : g_map
            assign w_loc[j] = w_entry[g * lrtd_pkg::GROUP_SIZE + j];
        end

        lrtd_group u_group (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (r_state == S_GRP),
            .i_match  (w_match[g * lrtd_pkg::GROUP_SIZE +: lrtd_pkg::GROUP_SIZE]),
            .i_entry  (w_loc),
            .o_any    (w_gany[g]),
            .o_before (w_inbefore[g * lrtd_pkg::GROUP_SIZE +: lrtd_pkg::GROUP_SIZE]),
            .o_first  (w_gent[g])
        );
    end

    // Second level: pick the first group that matched and take its first entry.
    always_comb begin
        logic [lrtd_pkg::NUM_GROUPS-1:0] p;
        p = w_gany;
        for (int k = 0; k < lrtd_pkg::GRP_LOG; k++) begin
            p = p | (p << (1 << k));
        end
        w_gbefore = p << 1;
        w_gfirst  = w_gany & ~w_gbefore;
        w_sel_ent = '0;
        for (int g = 0; g < lrtd_pkg::NUM_GROUPS; g++) begin
            if (w_gfirst[g]) begin
                w_sel_ent = lrtd_pkg::t_entry'(w_sel_ent | w_gent[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEL) begin
            r_hit     <= |w_gany;
            r_hit_ent <= w_sel_ent;
            r_gbefore <= w_gbefore;
        end
    end

    // Output register. A lookup miss reports all fields as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            if (r_key_op) begin
                r_out_hit     <= 1'b1;
                r_out_slot    <= w_ins_slot;
                r_out_chunk   <= r_key_chunk;
                r_out_bytes   <= r_key_bytes;
                r_out_evicted <= w_full;
            end else if (r_hit) begin
                r_out_hit     <= 1'b1;
                r_out_slot    <= r_hit_ent.slot;
                r_out_chunk   <= r_hit_ent.chunk;
                r_out_bytes   <= r_hit_ent.bytes;
                r_out_evicted <= 1'b0;
            end else begin
                r_out_hit     <= 1'b0;
                r_out_slot    <= '0;
                r_out_chunk   <= '0;
                r_out_bytes   <= '0;
                r_out_evicted <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_slot         = lrtd_pkg::SLOT_OUT_W'(r_out_slot);
    assign o_region_start = lrtd_pkg::OFFSET_W'({r_out_chunk, {lrtd_pkg::CHUNK_SHIFT{1'b0}}});
    assign o_region_bytes = r_out_bytes;
    assign o_evicted      = r_out_evicted;

    // The occupancy count never runs past the directory size.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lrtd_pkg::OCC_W'(lrtd_pkg::ENTRIES))
        else $error("occupancy exceeds directory size");

    // At most one group is chosen as holding the first match.
    a_one_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_gfirst))
        else $error("more than one group selected");

    // An accepted insert goes straight to commit.
    a_ins_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_operation |=> r_state == S_COMMIT)
        else $error("insert did not go to commit");

    // An eviction is only reported once the directory is full.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_evicted |-> w_full)
        else $error("eviction reported while not full");

endmodule

@@ rtl/lrtd_cell.sv @@
// One recency position of the directory: holds an entry and compares it to the key.
module lrtd_cell (
    input  logic                        i_clk,
    input  logic                        i_live,
    input  logic [lrtd_pkg::HASH_W-1:0] i_key_hash,
    input  logic [lrtd_pkg::CHUNK_W-1:0] i_key_chunk,
    input  logic                        i_cmp_en,
    input  logic                        i_shift,
    input  lrtd_pkg::t_entry            i_prev,
    output lrtd_pkg::t_entry            o_entry,
    output logic                        o_match
);

    lrtd_pkg::t_entry r_entry;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
        if (i_cmp_en) begin
            r_match <= i_live && (r_entry.hash == i_key_hash) && (r_entry.chunk == i_key_chunk);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ rtl/lrtd_group.sv @@
// Priority reduction over one group of cells: any match, prefix flags and first entry.
module lrtd_group (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [lrtd_pkg::GROUP_SIZE-1:0]   i_match,
    input  lrtd_pkg::t_entry                  i_entry [lrtd_pkg::GROUP_SIZE],
    output logic                              o_any,
    output logic [lrtd_pkg::GROUP_SIZE-1:0]   o_before,
    output lrtd_pkg::t_entry                  o_first
);

    logic [lrtd_pkg::GROUP_SIZE-1:0] w_before;
    lrtd_pkg::t_entry                w_first_ent;
    logic                            r_any;
    logic [lrtd_pkg::GROUP_SIZE-1:0] r_before;
    lrtd_pkg::t_entry                r_first;

    // Log-depth prefix OR; the first match is the one with no match ahead of it.
    always_comb begin
        logic [lrtd_pkg::GROUP_SIZE-1:0] p;
        logic [lrtd_pkg::GROUP_SIZE-1:0] first;
        p = i_match;
        for (int k = 0; k < lrtd_pkg::GS_LOG; k++) begin
            p = p | (p << (1 << k));
        end
        w_before    = p << 1;
        first       = i_match & ~w_before;
        w_first_ent = '0;
        for (int j = 0; j < lrtd_pkg::GROUP_SIZE; j++) begin
            if (first[j]) begin
                w_first_ent = lrtd_pkg::t_entry'(w_first_ent | i_entry[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_en) begin
            r_any <= |i_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_before <= w_before;
            r_first  <= w_first_ent;
        end
    end

    assign o_any    = r_any;
    assign o_before = r_before;
    assign o_first  = r_first;

endmodule
